// ===== rtl/scta_pkg.sv =====
// Shared types, scan code constants and translation tables for the scan code to ASCII FIFO.
package scta_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 64;

  localparam logic [7:0] SC_REL_BIT = 8'h80;
  localparam logic [6:0] SC_ESC     = 7'h01;
  localparam logic [6:0] SC_LSHIFT  = 7'h2A;
  localparam logic [6:0] SC_RSHIFT  = 7'h36;
  localparam logic [6:0] SC_CAPS    = 7'h3A;
  localparam logic [6:0] SC_F1      = 7'h3B;
  localparam logic [6:0] SC_F2      = 7'h3C;
  localparam logic [6:0] SC_F3      = 7'h3D;
  localparam logic [6:0] SC_F4      = 7'h3E;
  localparam logic [6:0] SC_F12     = 7'h58;

  typedef enum logic {
    FUNC_SCAN = 1'b0,
    FUNC_READ = 1'b1
  } scta_func_t;

  typedef struct packed {
    logic       func;
    logic [7:0] scan_code;
  } scta_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [6:0] char_out;
    logic       buffer_empty;
    logic       char_dropped;
  } scta_out_t;

  // What one scan code does to the keyboard state and the buffer.
  typedef struct packed {
    logic       push;
    logic       set_shift;
    logic       clr_shift;
    logic       tog_caps;
    logic [6:0] ch;
  } scta_action_t;

  // Unshifted key map; codes past the space bar give 0.
  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] c;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0D;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_upper(input logic [6:0] c);
    return (c >= 7'h41) && (c <= 7'h5A);
  endfunction

  function automatic logic is_lower(input logic [6:0] c);
    return (c >= 7'h61) && (c <= 7'h7A);
  endfunction

  // Shifted key map: symbol row and punctuation differ, letters go upper case.
  function automatic logic [6:0] shift_char(input logic [6:0] code);
    logic [6:0] p;
    logic [6:0] c;
    p = plain_char(code);
    case (code)
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      default: c = is_lower(p) ? (p ^ 7'h20) : p;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/scan_code_to_ascii_fifo.sv =====
// Top level: scan code set 1 to ASCII translator with a character buffer.
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+---------------------
//  input   | in        | scta_in_t  | in_valid / in_ready
//  output  | out       | scta_out_t | out_valid / out_ready
//
// One request per cycle unless the result stalls, one result per request.
// All decoding and buffer bookkeeping happen in the cycle a request is taken;
// the result register (and the buffer's read data register) carry it out.
// Reset (rst, synchronous) clears shift and caps lock, empties the buffer
// and drops the pending result; buffer contents are not cleared.
// A stalled result holds; a new request is still taken in the cycle the held
// result leaves, so the rate is set by the single output register.
module scan_code_to_ascii_fifo #(
  parameter int unsigned FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scta_pkg::scta_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scta_pkg::scta_out_t out_data
);
  import scta_pkg::*;

  // keyboard state
  logic shift_held;
  logic caps_on;

  // result register (character comes from the buffer's read register)
  logic res_char_valid;
  logic res_empty;
  logic res_dropped;

  logic         accept;
  logic         is_read;
  scta_action_t act;
  logic         fifo_full;
  logic         fifo_empty;
  logic         fifo_wr;
  logic         fifo_rd;
  logic [6:0]   fifo_rd_data;

  scta_decode u_decode (
    .scan_code  (in_data.scan_code),
    .shift_held (shift_held),
    .caps_on    (caps_on),
    .act        (act)
  );

  // Output register frees up when empty or being drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_read  = (in_data.func == FUNC_READ);

  assign fifo_wr = accept && !is_read && act.push && !fifo_full;
  assign fifo_rd = accept && is_read && !fifo_empty;

  scta_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fifo_wr),
    .wr_data (act.ch),
    .rd_en   (fifo_rd),
    .rd_data (fifo_rd_data),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
    end else if (accept && !is_read) begin
      if (act.set_shift) begin
        shift_held <= 1'b1;
      end else if (act.clr_shift) begin
        shift_held <= 1'b0;
      end
      if (act.tog_caps) begin
        caps_on <= !caps_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_char_valid <= is_read && !fifo_empty;
      res_empty      <= is_read && fifo_empty;
      res_dropped    <= !is_read && act.push && fifo_full;
    end
  end

  always_comb begin
    out_data              = '0;
    out_data.char_valid   = res_char_valid;
    out_data.char_out     = res_char_valid ? fifo_rd_data : 7'h00;
    out_data.buffer_empty = res_empty;
    out_data.char_dropped = res_dropped;
  end

endmodule

// ===== rtl/scta_decode.sv =====
// Scan code decoder: flag updates, key map lookup and caps lock case swap.
module scta_decode (
  input  logic [7:0]            scan_code,
  input  logic                  shift_held,
  input  logic                  caps_on,
  output scta_pkg::scta_action_t act
);
  import scta_pkg::*;

  logic [6:0] code;
  logic [6:0] mapped;
  logic       is_shift;

  assign code     = scan_code[6:0];
  assign is_shift = (code == SC_LSHIFT) || (code == SC_RSHIFT);

  always_comb begin
    mapped = shift_held ? shift_char(code) : plain_char(code);
    act    = '0;
    if ((scan_code & SC_REL_BIT) != 8'h00) begin
      act.clr_shift = is_shift;
    end else if (code == SC_ESC) begin
      act = '0;
    end else if (is_shift) begin
      act.set_shift = 1'b1;
    end else if (code == SC_CAPS) begin
      act.tog_caps = 1'b1;
    end else if (code == SC_F1 || code == SC_F2 || code == SC_F3 || code == SC_F4 ||
                 code == SC_F12) begin
      act = '0;
    end else begin
      act.push = 1'b1;
      // caps lock flips letter case only
      act.ch   = (caps_on && (is_upper(mapped) || is_lower(mapped))) ?
                 (mapped ^ 7'h20) : mapped;
    end
  end

endmodule

// ===== rtl/scta_fifo.sv =====
// Character buffer: circular memory with fill count and registered read data.
module scta_fifo #(
  parameter int unsigned DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [6:0] wr_data,
  input  logic       rd_en,
  output logic [6:0] rd_data,
  output logic       full,
  output logic       empty
);
  import scta_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [6:0]    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/scta_chk.sv =====
// Port-level checker for the scan code to ASCII FIFO, with its bind.
module scta_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input scta_pkg::scta_out_t out_data
);
  import scta_pkg::*;

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // each request gives one result next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // a result is a read hit, a read miss or a scan code outcome, never a mix
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({out_data.char_valid, out_data.buffer_empty,
                               out_data.char_dropped}) <= 1))
    else $error("conflicting result flags");

  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.char_valid |-> out_data.char_out == 7'h00)
    else $error("character shown without a read hit");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind scan_code_to_ascii_fifo scta_chk u_scta_chk (.*);

// ===== tb/testbench.sv =====
// Testbench for scan_code_to_ascii_fifo: key translation, buffer and handshake checks.
`timescale 1ns / 1ps

module testbench;
  import scta_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int BUF_DEPTH    = FIFO_DEPTH_DEF;
  localparam int HOLD_CYCLES  = 150;   // long receiver stall to back up the input
  localparam int DRAIN_LIMIT  = 2000;  // cycles allowed for outstanding results at the end
  localparam int MAX_PRINTS   = 50;

  // Scoreboard: keeps its own keyboard state and character buffer, predicts
  // one result per accepted request and checks results in order.
  class key_scoreboard;
    logic [6:0] plain_keys [58];
    logic [6:0] shifted_keys [58];
    logic       shift_on;
    logic       caps_lock;
    logic [6:0] buffered_chars [$];
    scta_out_t  pending [$];
    int         depth;
    int         errors;

    function new(int buf_depth);
      depth     = buf_depth;
      errors    = 0;
      shift_on  = 1'b0;
      caps_lock = 1'b0;
      plain_keys = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20};
      shifted_keys = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20};
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Key map lookup with caps lock case swap; codes past the space bar give 0.
    function logic [6:0] translate_key(input logic [6:0] code);
      logic [6:0] ch;
      ch = 7'h00;
      if (code < 7'd58) ch = shift_on ? shifted_keys[code] : plain_keys[code];
      if (caps_lock && ((ch >= 7'h41 && ch <= 7'h5A) || (ch >= 7'h61 && ch <= 7'h7A)))
        ch = ch ^ 7'h20;
      return ch;
    endfunction

    function void note_request(input scta_in_t req);
      scta_out_t  res;
      logic [6:0] code;
      res  = '0;
      code = req.scan_code[6:0];
      if (scta_func_t'(req.func) == FUNC_READ) begin
        if (buffered_chars.size() == 0) begin
          res.buffer_empty = 1'b1;
        end else begin
          res.char_valid = 1'b1;
          res.char_out   = buffered_chars.pop_front();
        end
      end else if ((req.scan_code & SC_REL_BIT) != 8'h00) begin
        // only shift releases matter
        if (code == SC_LSHIFT || code == SC_RSHIFT) shift_on = 1'b0;
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_on = 1'b1;
      end else if (code == SC_CAPS) begin
        caps_lock = !caps_lock;
      end else if (code == SC_ESC || code == SC_F1 || code == SC_F2 || code == SC_F3 ||
                   code == SC_F4 || code == SC_F12) begin
        // silent keys
      end else if (buffered_chars.size() >= depth) begin
        res.char_dropped = 1'b1;
      end else begin
        buffered_chars.push_back(translate_key(code));
      end
      pending.push_back(res);
    endfunction

    task check_result(input scta_out_t got);
      scta_out_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = pending.pop_front();
      if (got.char_valid !== want.char_valid)
        report($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
      if (got.char_out !== want.char_out)
        report($sformatf("char_out %h, want %h", got.char_out, want.char_out));
      if (got.buffer_empty !== want.buffer_empty)
        report($sformatf("buffer_empty %b, want %b", got.buffer_empty, want.buffer_empty));
      if (got.char_dropped !== want.char_dropped)
        report($sformatf("char_dropped %b, want %b", got.char_dropped, want.char_dropped));
    endtask
  endclass

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  scta_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  scta_out_t out_data;

  key_scoreboard book;
  int        sent      = 0;
  logic      calm      = 1'b0;  // no idling on either side while set
  logic      hold_out  = 1'b0;  // asks the receiver for a long stall

  scan_code_to_ascii_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Monitor: values seen here are the ones sampled at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) book.note_request(in_data);
      if (out_valid && out_ready) book.check_result(out_data);
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // Offer one request and wait for it to be taken. in_valid only drops when
  // an idle gap actually follows, so it is never lowered and raised in one step.
  task automatic send_request(input scta_func_t func, input logic [7:0] code);
    scta_in_t req;
    int       gap;
    req.func      = func;
    req.scan_code = code;
    calm = (sent >= 300 && sent < 450);
    if (sent == 700) hold_out = 1'b1;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Random keystroke: mostly mapped presses, plus releases, modifiers,
  // silent keys and raw bytes.
  function automatic logic [7:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 8'($urandom_range(8'h39, 8'h02));
    if (roll < 65) return {1'b1, 7'($urandom_range(127))};
    if (roll < 72) return {1'b0, ($urandom_range(1) != 0) ? SC_LSHIFT : SC_RSHIFT};
    if (roll < 79) return SC_REL_BIT | {1'b0, ($urandom_range(1) != 0) ? SC_LSHIFT : SC_RSHIFT};
    if (roll < 83) return {1'b0, SC_CAPS};
    if (roll < 88) begin
      case ($urandom_range(5))
        0: return {1'b0, SC_ESC};
        1: return {1'b0, SC_F1};
        2: return {1'b0, SC_F2};
        3: return {1'b0, SC_F3};
        4: return {1'b0, SC_F4};
        default: return {1'b0, SC_F12};
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // One burst of typing: read_pct sets the share of reads.
  task automatic type_burst(input int len, input int read_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < read_pct) send_request(FUNC_READ, 8'($urandom_range(255)));
      else send_request(FUNC_SCAN, pick_key());
    end
  endtask

  // Stream of presses from codes 0x02 to 0x39 with no reads, enough to overflow the buffer.
  task automatic flood(input int len);
    for (int i = 0; i < len; i++) send_request(FUNC_SCAN, 8'($urandom_range(8'h39, 8'h02)));
  endtask

  // Fully random requests.
  task automatic noise(input int len);
    for (int i = 0; i < len; i++)
      send_request(scta_func_t'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    logic [7:0] opening [$];
    int         kind;
    int         waited;

    book = new(BUF_DEPTH);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: read while empty, shift and caps combinations, both shift
    // keys, silent keys, unmapped codes and a stray release.
    send_request(FUNC_READ, 8'h00);
    opening = '{8'h1E, {1'b0, SC_LSHIFT}, 8'h1E, 8'h02, SC_REL_BIT | {1'b0, SC_LSHIFT},
                {1'b0, SC_RSHIFT}, 8'h35, SC_REL_BIT | {1'b0, SC_RSHIFT},
                {1'b0, SC_CAPS}, 8'h10, {1'b0, SC_LSHIFT}, 8'h10,
                SC_REL_BIT | {1'b0, SC_LSHIFT}, {1'b0, SC_CAPS}, {1'b0, SC_ESC},
                {1'b0, SC_F1}, {1'b0, SC_F2}, {1'b0, SC_F3}, {1'b0, SC_F4},
                {1'b0, SC_F12}, 8'h1D, 8'h7F, 8'hFF, 8'h39};
    foreach (opening[i]) send_request(FUNC_SCAN, opening[i]);

    // Random phases: fill, drain, overflow and noise.
    flood(80);
    type_burst(80, 90);
    while (sent < RANDOM_ITEMS + 25) begin
      kind = $urandom_range(99);
      if (kind < 10) flood($urandom_range(80, 70));
      else if (kind < 55) type_burst($urandom_range(40, 5), 25);
      else if (kind < 85) type_burst($urandom_range(40, 5), 75);
      else noise($urandom_range(15, 3));
    end
    in_valid <= 1'b0;

    waited = 0;
    while (book.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (book.pending.size() != 0)
      book.report($sformatf("%0d results never arrived", book.pending.size()));
    repeat (10) @(posedge clk);

    if (book.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/scta_pkg.sv
rtl/scta_decode.sv
rtl/scta_fifo.sv
rtl/scan_code_to_ascii_fifo.sv
rtl/scta_chk.sv
tb/testbench.sv
